// ----- design/cme_pkg.sv -----
// ----------------------------------------------------------------------------
// cme_pkg: shared types and constants for the crop/mirror/erase/normalize block
// Field widths, register indexes, mean modes and the result beat layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cme_pkg;

  localparam int MAX_DIM  = 1024;
  localparam int CHANNELS = 3;

  localparam int CHAN_W  = 2;
  localparam int POS_W   = 10;
  localparam int PIX_W   = 8;
  localparam int MEAN_W  = 16;
  localparam int IDX_W   = 22;
  localparam int VAL_W   = 32;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 64;

  typedef enum logic [CIDX_W-1:0] {
    REG_CROP_BOX      = 3'd0,
    REG_ERASE_BOX     = 3'd1,
    REG_CHANNEL_MEANS = 3'd2,
    REG_SCALE_FACTOR  = 3'd3,
    REG_MODE_BITS     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MEAN_NONE    = 2'd0,
    MEAN_CHANNEL = 2'd1,
    MEAN_PIXEL   = 2'd2
  } mean_mode_t;

  localparam logic [63:0] CROP_BOX_RST      = 64'd0;
  localparam logic [63:0] ERASE_BOX_RST     = 64'd65535;
  localparam logic [47:0] CHANNEL_MEANS_RST = 48'd0;
  localparam logic [23:0] SCALE_FACTOR_RST  = 24'd65536;
  localparam logic [2:0]  MODE_BITS_RST     = 3'd0;

  typedef struct packed {
    logic                    keep;
    logic [IDX_W-1:0]        dest_index;
    logic signed [VAL_W-1:0] value;
  } res_t;

endpackage

// ----- design/cme_if.sv -----
// ----------------------------------------------------------------------------
// cme_if: channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cme_pix_in_if;
  import cme_pkg::*;
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   chan;
  logic [POS_W-1:0]    src_row;
  logic [POS_W-1:0]    src_col;
  logic [PIX_W-1:0]    pixel;
  logic [PIX_W-1:0]    erase_fill;
  logic [MEAN_W-1:0]   pixel_mean;

  modport source (output valid, chan, src_row, src_col, pixel, erase_fill, pixel_mean,
                  input ready);
  modport sink (input valid, chan, src_row, src_col, pixel, erase_fill, pixel_mean,
                output ready);
endinterface

interface cme_pix_out_if;
  import cme_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    keep;
  logic [IDX_W-1:0]        dest_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, keep, dest_index, value, input ready);
  modport sink (input valid, keep, dest_index, value, output ready);
endinterface

interface cme_cfg_if;
  import cme_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/cme_skid.sv -----
// ----------------------------------------------------------------------------
// cme_skid: output register with skid stage
// Holds a result beat for the sink; a second entry catches the beat in
// flight when the sink stalls, so the upstream ready is a register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cme_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cme_pkg::res_t in_data,
  cme_pix_out_if.source pix_out
);
  import cme_pkg::*;

  logic out_valid;
  res_t out_data;
  logic sk_valid;
  res_t sk_data;

  assign in_ready = !sk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (out_valid && !pix_out.ready) begin
      if (in_valid && !sk_valid) begin
        sk_valid <= 1'b1;
      end
    end else if (sk_valid) begin
      out_valid <= 1'b1;
      sk_valid  <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !pix_out.ready) begin
      if (in_valid && !sk_valid) begin
        sk_data <= in_data;
      end
    end else if (sk_valid) begin
      out_data <= sk_data;
    end else begin
      out_data <= in_data;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.keep       = out_data.keep;
  assign pix_out.dest_index = out_data.dest_index;
  assign pix_out.value      = out_data.value;

endmodule

// ----- design/crop_mirror_erase_normalize.sv -----
// ----------------------------------------------------------------------------
// crop_mirror_erase_normalize: crop window, mirror, random erase, normalize
// Throughput: one pixel per cycle while the output does not stall; four
// pipeline stages, the multiply stage (18x25 scale product and 22x16 index
// product) sets the cycle.
// Reset: synchronous; clears valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crop_mirror_erase_normalize (
  input  logic          clk,
  input  logic          rst,
  cme_pix_in_if.sink    pix_in,
  cme_pix_out_if.source pix_out,
  cme_cfg_if.sink       cfg
);
  import cme_pkg::*;

  // configuration registers
  logic [63:0] crop_box;
  logic [63:0] erase_box;
  logic [47:0] channel_means;
  logic [23:0] scale_factor;
  logic [2:0]  mode_bits;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_box      <= CROP_BOX_RST;
      erase_box     <= ERASE_BOX_RST;
      channel_means <= CHANNEL_MEANS_RST;
      scale_factor  <= SCALE_FACTOR_RST;
      mode_bits     <= MODE_BITS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_CROP_BOX:      crop_box      <= cfg.data;
        REG_ERASE_BOX:     erase_box     <= cfg.data;
        REG_CHANNEL_MEANS: channel_means <= cfg.data[47:0];
        REG_SCALE_FACTOR:  scale_factor  <= cfg.data[23:0];
        REG_MODE_BITS:     mode_bits     <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  logic [15:0] crop_h, crop_w, top, left;
  logic [15:0] ymax, ymin, xmax, xmin;
  logic        mirror;
  assign crop_h = crop_box[63:48];
  assign crop_w = crop_box[47:32];
  assign top    = crop_box[31:16];
  assign left   = crop_box[15:0];
  assign ymax   = erase_box[63:48];
  assign ymin   = erase_box[47:32];
  assign xmax   = erase_box[31:16];
  assign xmin   = erase_box[15:0];
  assign mirror = mode_bits[0];

  // pipeline advance: stage 4 empty or the skid can take its beat
  logic en;
  logic sk_ready;

  logic v1, v2, v3, v4;
  assign en           = !v4 || sk_ready;
  assign pix_in.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= pix_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: range checks, offsets, mean select, channel times crop height
  logic              pre1;
  logic [POS_W-1:0]  r1, c1;
  logic [PIX_W-1:0]  pix1, fill1;
  logic [MEAN_W-1:0] mean1;
  logic [IDX_W-1:0]  chh1;

  logic              pre_next;
  logic [MEAN_W-1:0] mean_next;
  logic [MEAN_W-1:0] chan_mean;

  always_comb begin
    pre_next = (32'(pix_in.chan) < 32'(CHANNELS))
            && (32'(pix_in.src_row) < 32'(MAX_DIM))
            && (32'(pix_in.src_col) < 32'(MAX_DIM))
            && ({6'b0, pix_in.src_row} >= top)
            && ({6'b0, pix_in.src_col} >= left);
    case (pix_in.chan)
      2'd0:    chan_mean = channel_means[15:0];
      2'd1:    chan_mean = channel_means[31:16];
      2'd2:    chan_mean = channel_means[47:32];
      default: chan_mean = '0;
    endcase
    unique case (mean_mode_t'(mode_bits[2:1]))
      MEAN_CHANNEL: mean_next = chan_mean;
      MEAN_PIXEL:   mean_next = pix_in.pixel_mean;
      default:      mean_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre1  <= pre_next;
      // only meaningful when the offset checks pass, so 10 bits suffice
      r1    <= pix_in.src_row - top[POS_W-1:0];
      c1    <= pix_in.src_col - left[POS_W-1:0];
      pix1  <= pix_in.pixel;
      fill1 <= pix_in.erase_fill;
      mean1 <= mean_next;
      chh1  <= IDX_W'(IDX_W'(pix_in.chan) * IDX_W'(crop_h));
    end
  end

  // stage 2: window and erase compares, mean subtraction, mirror
  logic               keep2;
  logic signed [17:0] d2;
  logic [15:0]        dc2;
  logic [IDX_W-1:0]   t2;

  logic               erase;
  logic [PIX_W-1:0]   samp;
  logic [15:0]        c1w, r1w;

  always_comb begin
    c1w   = {6'b0, c1};
    r1w   = {6'b0, r1};
    erase = (c1w >= xmin) && (c1w <= xmax) && (r1w >= ymin) && (r1w <= ymax);
    samp  = erase ? fill1 : pix1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      keep2 <= pre1 && (r1w < crop_h) && (c1w < crop_w);
      d2    <= $signed({2'b0, samp, 8'b0}) - $signed({2'b0, mean1});
      dc2   <= mirror ? (crop_w - 16'd1 - c1w) : c1w;
      t2    <= chh1 + IDX_W'(r1);
    end
  end

  // stage 3: scale product and row-major index product
  logic               keep3;
  logic signed [42:0] prod3;
  logic [IDX_W-1:0]   idx3;
  logic [15:0]        dc3;

  always_ff @(posedge clk) begin
    if (en) begin
      keep3 <= keep2;
      prod3 <= 43'(d2) * 43'($signed({1'b0, scale_factor}));
      idx3  <= IDX_W'(t2 * IDX_W'(crop_w));
      dc3   <= dc2;
    end
  end

  // stage 4: round half up to Q16.16, saturate, add column
  logic signed [43:0] rsum;
  logic signed [35:0] rq;
  logic [VAL_W-1:0]   sat;
  res_t               res4;

  always_comb begin
    rsum = 44'(prod3) + 44'sd128;
    rq   = rsum[43:8];
    if (rq[35:31] == 5'b00000 || rq[35:31] == 5'b11111) begin
      sat = rq[31:0];
    end else if (rq[35]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res4.keep       <= keep3;
      res4.dest_index <= keep3 ? (idx3 + IDX_W'(dc3)) : '0;
      res4.value      <= keep3 ? $signed(sat) : '0;
    end
  end

  cme_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v4),
    .in_ready (sk_ready),
    .in_data  (res4),
    .pix_out  (pix_out)
  );

`ifndef SYNTHESIS
  // a dropped pixel carries zero payload
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && !pix_out.keep |-> pix_out.dest_index == '0 && pix_out.value == '0)
    else $error("dropped pixel with non-zero payload");

  // the pipeline only stalls when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> pix_out.valid)
    else $error("pipeline stalled with empty output");

  // a stalled last stage keeps its beat
  a_s4_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !en |=> v4 && $stable(res4))
    else $error("stage 4 beat lost under stall");
`endif

endmodule
